### src/assert_macros.svh
// assertion macros shared by the probe rtl
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define VPP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define VPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/vpp_pkg.sv
// shared types and constants for the video pixel probe
// no dependencies; imported by every probe module
package vpp_pkg;

	localparam int POS_W            = 27;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;
	localparam int MAX_FRAME_WIDTH  = 8192;
	localparam int MAX_FRAME_HEIGHT = 8192;
	// round-up reciprocal of six in 16 fraction bits, exact for 13-bit columns
	localparam int RECIP_SIX        = 10923;
	localparam int SETTLE_CYCLES    = 4;

	typedef enum logic [3:0] {
		FMT_V210  = 4'd0,
		FMT_2VUY  = 4'd1,
		FMT_R210  = 4'd2,
		FMT_R10L  = 4'd3,
		FMT_R10B  = 4'd4,
		FMT_12BE  = 4'd5,
		FMT_12LE  = 4'd6,
		FMT_BGRA  = 4'd7,
		FMT_ARGB  = 4'd8
	} fmt_t;

	typedef enum logic [1:0] {
		KIND_YCBCR = 2'd0,
		KIND_RGB   = 2'd1,
		KIND_NONE  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORMAT  = 3'd0,
		REG_PROBE_X = 3'd1,
		REG_PROBE_Y = 3'd2,
		REG_WIDTH   = 3'd3,
		REG_HEIGHT  = 3'd4,
		REG_PITCH   = 3'd5
	} reg_idx_t;

	// probe geometry derived from the configuration
	typedef struct packed {
		fmt_t             fmt;
		kind_t            kind;
		logic             supported;
		logic [12:0]      x;
		logic [12:0]      y;
		logic [POS_W-1:0] start;
		logic [POS_W:0]   end_pos;
		logic [2:0]       grp_pos;
		logic [1:0]       boff;
	} geo_t;

	// snapshot handed from capture to unpack for one frame end
	typedef struct packed {
		logic [3:0][31:0] window;
		logic             found;
		fmt_t             fmt;
		kind_t            kind;
		logic [12:0]      x;
		logic [12:0]      y;
		logic [2:0]       grp_pos;
		logic [1:0]       boff;
	} probe_t;

endpackage

### src/vpp_geometry.sv
// configuration registers and the staged address computation of the probe
// depends on vpp_pkg
module vpp_geometry import vpp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output geo_t                  geo,
	output logic                  busy
);

	fmt_t             fmt_q;
	logic [13:0]      px_q;
	logic [13:0]      py_q;
	logic [13:0]      fw_q;
	logic [13:0]      fh_q;
	logic [15:0]      pitch_q;
	logic [12:0]      x_q;
	logic [12:0]      y_q;
	logic [POS_W-1:0] line_q;
	logic [10:0]      quot_q;
	logic [POS_W-1:0] start_q;
	logic [2:0]       grp_pos_q;
	logic [POS_W:0]   end_q;
	logic [2:0]       settle_q;
	logic [26:0]      quot_prod;
	logic [14:0]      x_times3;
	logic [14:0]      xterm;
	logic [12:0]      six_quot;
	logic [1:0]       need_m1;

	function automatic logic [12:0] clamp_coord(input logic [13:0] raw,
		input logic [13:0] size, input logic [16:0] max_size);
		logic [16:0] sz;
		sz = {3'b000, size};
		if (sz == 17'd0)
			sz = 17'd1;
		if (sz > max_size)
			sz = max_size;
		if (raw[13])
			return 13'd0;
		else if ({4'b0000, raw[12:0]} >= sz)
			return 13'(sz - 17'd1);
		else
			return raw[12:0];
	endfunction

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_V210;
			px_q    <= 14'd960;
			py_q    <= 14'd540;
			fw_q    <= 14'd1920;
			fh_q    <= 14'd1080;
			pitch_q <= 16'd5120;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FORMAT:  fmt_q   <= fmt_t'(cfg_data[3:0]);
				REG_PROBE_X: px_q    <= cfg_data[13:0];
				REG_PROBE_Y: py_q    <= cfg_data[13:0];
				REG_WIDTH:   fw_q    <= cfg_data[13:0];
				REG_HEIGHT:  fh_q    <= cfg_data[13:0];
				REG_PITCH:   pitch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// settle counter, restarted by reset and by every register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			settle_q <= 3'(SETTLE_CYCLES);
		else if (cfg_valid)
			settle_q <= 3'(SETTLE_CYCLES);
		else if (settle_q != 3'd0)
			settle_q <= settle_q - 3'd1;
	end

	assign busy = (settle_q != 3'd0);

	// per-format word offset of the pixel inside its line
	always_comb begin
		quot_prod = {14'd0, x_q} * 27'(RECIP_SIX);
		x_times3  = {1'b0, x_q, 1'b0} + {2'b00, x_q};
		six_quot  = {quot_q, 2'b00} + {1'b0, quot_q, 1'b0};
		case (fmt_q)
			FMT_V210: begin
				xterm   = {2'b00, quot_q, 2'b00};
				need_m1 = 2'd3;
			end
			FMT_2VUY: begin
				xterm   = {3'b000, x_q[12:1]};
				need_m1 = 2'd0;
			end
			FMT_12BE, FMT_12LE: begin
				xterm   = {1'b0, x_times3[14:1]};
				need_m1 = 2'd1;
			end
			default: begin
				xterm   = {2'b00, x_q};
				need_m1 = 2'd0;
			end
		endcase
	end

	// clamp, multiply, add, add: one step per cycle
	always_ff @(posedge clk) begin
		x_q       <= clamp_coord(px_q, fw_q, 17'(MAX_FRAME_WIDTH));
		y_q       <= clamp_coord(py_q, fh_q, 17'(MAX_FRAME_HEIGHT));
		line_q    <= {14'd0, y_q} * {13'd0, pitch_q[15:2]};
		quot_q    <= quot_prod[26:16];
		start_q   <= line_q + {12'd0, xterm};
		grp_pos_q <= 3'(x_q - six_quot);
		end_q     <= {1'b0, start_q} + {26'd0, need_m1};
	end

	// geometry bundle for the capture stage
	always_comb begin
		geo.fmt       = fmt_q;
		geo.supported = (fmt_q <= FMT_ARGB);
		if (fmt_q > FMT_ARGB)
			geo.kind = KIND_NONE;
		else if (fmt_q <= FMT_2VUY)
			geo.kind = KIND_YCBCR;
		else
			geo.kind = KIND_RGB;
		geo.x       = x_q;
		geo.y       = y_q;
		geo.start   = start_q;
		geo.end_pos = end_q;
		geo.grp_pos = grp_pos_q;
		geo.boff    = {x_q[0], 1'b0};
	end

endmodule

### src/vpp_capture.sv
// word counting, window capture and the frame-end snapshot register
// depends on vpp_pkg
module vpp_capture import vpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] frame_word,
	input  logic        first_word,
	input  logic        last_word,
	input  geo_t        geo,
	input  logic        busy,
	output logic        snap_valid,
	input  logic        snap_ready,
	output probe_t      snap
);

	logic [POS_W-1:0] pos_q;
	logic [3:0][31:0] window_q;
	logic             captured_q;
	logic             snap_valid_s1;
	probe_t           snap_s1;
	logic             accept;
	logic [POS_W-1:0] cur;
	logic [POS_W-1:0] rel;
	logic             hit;
	logic [3:0][31:0] window_next;
	logic             captured_next;
	logic             found;

	// hold off while geometry settles or the snapshot cannot move on
	assign in_stall = busy || (snap_valid_s1 && !snap_ready);
	assign accept   = in_valid && !in_stall;

	// position of this word and its place in the window
	always_comb begin
		cur         = first_word ? '0 : pos_q;
		rel         = cur - geo.start;
		hit         = geo.supported && (rel < POS_W'(4));
		window_next = window_q;
		if (hit)
			window_next[rel[1:0]] = frame_word;
		captured_next = (first_word ? 1'b0 : captured_q) || (hit && rel == '0);
		found         = geo.supported && captured_next && ({1'b0, cur} >= geo.end_pos);
	end

	// running frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			captured_q <= 1'b0;
		end else if (accept) begin
			pos_q      <= cur + POS_W'(1);
			captured_q <= captured_next;
		end
	end

	// window store, undefined until written
	always_ff @(posedge clk) begin
		if (accept)
			window_q <= window_next;
	end

	// snapshot valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			snap_valid_s1 <= 1'b0;
		else if (accept && last_word)
			snap_valid_s1 <= 1'b1;
		else if (snap_ready)
			snap_valid_s1 <= 1'b0;
	end

	// snapshot payload at the frame's last word
	always_ff @(posedge clk) begin
		if (accept && last_word) begin
			snap_s1.window  <= window_next;
			snap_s1.found   <= found;
			snap_s1.fmt     <= geo.fmt;
			snap_s1.kind    <= geo.kind;
			snap_s1.x       <= geo.x;
			snap_s1.y       <= geo.y;
			snap_s1.grp_pos <= geo.grp_pos;
			snap_s1.boff    <= geo.boff;
		end
	end

	assign snap_valid = snap_valid_s1;
	assign snap       = snap_s1;

endmodule

### src/vpp_unpack.sv
// component extraction for each packed format and the result register
// depends on vpp_pkg
module vpp_unpack import vpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        snap_valid,
	output logic        snap_ready,
	input  probe_t      snap,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] component_one,
	output logic [11:0] component_two,
	output logic [11:0] component_three,
	output logic [1:0]  colour_kind,
	output logic [12:0] column_used,
	output logic [12:0] row_used,
	output logic        pixel_found
);

	logic        out_valid_q;
	logic [11:0] c1_q;
	logic [11:0] c2_q;
	logic [11:0] c3_q;
	logic [1:0]  kind_q;
	logic [12:0] col_q;
	logic [12:0] row_q;
	logic        found_q;
	logic [31:0] w0;
	logic [31:0] w1;
	logic [31:0] w2;
	logic [31:0] w3;
	logic [15:0] h1;
	logic [15:0] h2;
	logic [15:0] h3;
	logic [11:0] c1;
	logic [11:0] c2;
	logic [11:0] c3;
	logic        load;

	assign snap_ready = !out_valid_q || !out_stall;
	assign load       = snap_valid && snap_ready;

	// unpack the captured window
	always_comb begin
		w0 = snap.window[0];
		w1 = snap.window[1];
		w2 = snap.window[2];
		w3 = snap.window[3];
		// halfwords start on byte 0 or byte 2 of the window
		if (snap.boff[1]) begin
			h1 = w0[31:16];
			h2 = w1[15:0];
			h3 = w1[31:16];
		end else begin
			h1 = w0[15:0];
			h2 = w0[31:16];
			h3 = w1[15:0];
		end
		c1 = '0;
		c2 = '0;
		c3 = '0;
		if (snap.found) begin
			case (snap.fmt)
				FMT_V210: begin
					case (snap.grp_pos)
						3'd0:    c1 = {2'b00, w0[19:10]};
						3'd1:    c1 = {2'b00, w1[9:0]};
						3'd2:    c1 = {2'b00, w1[29:20]};
						3'd3:    c1 = {2'b00, w2[19:10]};
						3'd4:    c1 = {2'b00, w3[9:0]};
						3'd5:    c1 = {2'b00, w3[29:20]};
						default: c1 = '0;
					endcase
					if (snap.grp_pos < 3'd2) begin
						c2 = {2'b00, w0[9:0]};
						c3 = {2'b00, w0[29:20]};
					end else if (snap.grp_pos < 3'd4) begin
						c2 = {2'b00, w1[19:10]};
						c3 = {2'b00, w2[9:0]};
					end else begin
						c2 = {2'b00, w2[29:20]};
						c3 = {2'b00, w3[19:10]};
					end
				end
				FMT_2VUY: begin
					c1 = snap.x[0] ? {4'h0, w0[31:24]} : {4'h0, w0[15:8]};
					c2 = {4'h0, w0[7:0]};
					c3 = {4'h0, w0[23:16]};
				end
				FMT_R210, FMT_R10B: begin
					c1 = {2'b00, w0[29:20]};
					c2 = {2'b00, w0[19:10]};
					c3 = {2'b00, w0[9:0]};
				end
				FMT_R10L: begin
					c1 = {2'b00, w0[31:22]};
					c2 = {2'b00, w0[21:12]};
					c3 = {2'b00, w0[11:2]};
				end
				FMT_12BE: begin
					c1 = h1[15:4];
					c2 = h2[15:4];
					c3 = h3[15:4];
				end
				FMT_12LE: begin
					c1 = h1[11:0];
					c2 = h2[11:0];
					c3 = h3[11:0];
				end
				FMT_BGRA: begin
					c1 = {4'h0, w0[23:16]};
					c2 = {4'h0, w0[15:8]};
					c3 = {4'h0, w0[7:0]};
				end
				FMT_ARGB: begin
					c1 = {4'h0, w0[15:8]};
					c2 = {4'h0, w0[23:16]};
					c3 = {4'h0, w0[31:24]};
				end
				default: begin
					c1 = '0;
					c2 = '0;
					c3 = '0;
				end
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (snap_ready)
			out_valid_q <= snap_valid;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			c1_q    <= c1;
			c2_q    <= c2;
			c3_q    <= c3;
			kind_q  <= snap.kind;
			col_q   <= snap.x;
			row_q   <= snap.y;
			found_q <= snap.found;
		end
	end

	assign out_valid       = out_valid_q;
	assign component_one   = c1_q;
	assign component_two   = c2_q;
	assign component_three = c3_q;
	assign colour_kind     = kind_q;
	assign column_used     = col_q;
	assign row_used        = row_q;
	assign pixel_found     = found_q;

endmodule

### src/video_pixel_probe.sv
// top level of the video pixel probe: geometry, capture and unpack stages
// depends on vpp_pkg, vpp_geometry, vpp_capture, vpp_unpack, assert_macros.svh
//
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
// in       | in_valid / in_stall    | frame_word, first_word, last_word
// out      | out_valid / out_stall  | component_one..three, colour_kind,
//          |                        | column_used, row_used, pixel_found
//
// one frame word per cycle while in_stall is low; a result is held in the
// frame-end snapshot register, then the result register. after reset and
// every register write in_stall is high while the pixel address is rebuilt
// (clamp, line multiply, add, end add). cfg_ready is always high.
// a held result stalls input only once the frame-end snapshot is also full.
// arst_n clears position, capture flag and valid flags; the window is not
// cleared.
`include "assert_macros.svh"

module video_pixel_probe import vpp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           frame_word,
	input  logic                  first_word,
	input  logic                  last_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [11:0]           component_one,
	output logic [11:0]           component_two,
	output logic [11:0]           component_three,
	output logic [1:0]            colour_kind,
	output logic [12:0]           column_used,
	output logic [12:0]           row_used,
	output logic                  pixel_found
);

	geo_t   geo;
	logic   busy;
	logic   snap_valid;
	logic   snap_ready;
	probe_t snap;

	// configuration and pixel address
	vpp_geometry u_geometry (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geo       (geo),
		.busy      (busy)
	);

	// word counting and window capture
	vpp_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_word (frame_word),
		.first_word (first_word),
		.last_word  (last_word),
		.geo        (geo),
		.busy       (busy),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	// component unpack and result register
	vpp_unpack u_unpack (
		.clk             (clk),
		.arst_n          (arst_n),
		.snap_valid      (snap_valid),
		.snap_ready      (snap_ready),
		.snap            (snap),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.component_one   (component_one),
		.component_two   (component_two),
		.component_three (component_three),
		.colour_kind     (colour_kind),
		.column_used     (column_used),
		.row_used        (row_used),
		.pixel_found     (pixel_found)
	);

	// no transaction while the pixel address is being rebuilt
	`VPP_ASSERT_NOW(a_settle_blocks_input, busy, in_stall, "word accepted during settle")
	// a held snapshot blocks input
	`VPP_ASSERT_NOW(a_snap_backpressure, snap_valid && !snap_ready, in_stall,
		"input open while snapshot is held")
	// a found pixel always comes with a supported format
	`VPP_ASSERT_NOW(a_found_supported, out_valid && pixel_found,
		colour_kind != KIND_NONE, "pixel found for unsupported format")
	// a register write restarts the settle window
	`VPP_ASSERT_NEXT(a_write_settles, cfg_valid && cfg_ready, busy,
		"register write did not restart settle")

endmodule

### dv/testbench.sv
// self-checking testbench for video_pixel_probe: directed table, then random frames
// depends on vpp_pkg and the probe rtl; predicts every report not typed in
`timescale 1ns / 100ps

module testbench;
	import vpp_pkg::*;

	typedef struct packed {
		logic [11:0] comp_one;
		logic [11:0] comp_two;
		logic [11:0] comp_three;
		kind_t       kind;
		logic [12:0] column;
		logic [12:0] row;
		logic        found;
	} pixel_report_t;

	typedef struct {
		bit            is_reg;
		reg_idx_t      index;
		logic [15:0]   value;
		logic [31:0]   word;
		logic          first;
		logic          last;
		bit            known;
		pixel_report_t report;
	} stim_row_t;

	localparam int DRAIN_CYCLES  = SETTLE_CYCLES + 4;
	localparam int RANDOM_PHASES = 48;
	localparam int RANDOM_WORDS  = 1700;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_idx_t              cfg_index = REG_FORMAT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [31:0]           frame_word = '0;
	logic                  first_word = 1'b0;
	logic                  last_word = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [11:0]           component_one;
	logic [11:0]           component_two;
	logic [11:0]           component_three;
	logic [1:0]            colour_kind;
	logic [12:0]           column_used;
	logic [12:0]           row_used;
	logic                  pixel_found;

	// side band that travels with each word: a typed-in report for known rows
	bit                    row_known = 1'b0;
	pixel_report_t         row_report = '0;

	// register copy and frame state of the predictor
	logic [3:0]            fmt_cfg = 4'd0;
	logic [13:0]           x_cfg = 14'd960;
	logic [13:0]           y_cfg = 14'd540;
	logic [13:0]           width_cfg = 14'd1920;
	logic [13:0]           height_cfg = 14'd1080;
	logic [15:0]           pitch_cfg = 16'd5120;
	logic [POS_W-1:0]      next_pos = '0;
	logic [31:0]           window [4] = '{default: '0};
	bit                    captured = 1'b0;

	pixel_report_t         awaited_reports [$];
	stim_row_t             directed_rows [$];
	int                    mismatches = 0;
	int                    words_sent = 0;
	int                    reports_checked = 0;
	int                    reg_writes = 0;
	int                    send_idle_pct = 0;
	int                    stall_pct = 0;

	video_pixel_probe dut (.*);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// coordinate clamp into a frame whose size is itself limited
	function automatic logic [12:0] clamp_axis(logic [13:0] raw, logic [13:0] size, int limit);
		int c;
		int s;
		c = $signed(raw);
		s = (size == 0) ? 1 : int'(size);
		if (s > limit)
			s = limit;
		if (c < 0)
			return '0;
		if (c >= s)
			return 13'(s - 1);
		return 13'(c);
	endfunction

	// pixel address: first word, words needed and byte offset within the window
	function automatic void locate_pixel(input logic [3:0] fmt, input logic [13:0] px, py,
			input logic [13:0] fw, fh, input logic [15:0] pitch, output logic [12:0] x, y,
			output longint start, output int need, output int boff);
		longint line;
		x = clamp_axis(px, fw, MAX_FRAME_WIDTH);
		y = clamp_axis(py, fh, MAX_FRAME_HEIGHT);
		line = longint'(y) * longint'(pitch >> 2);
		need = 1;
		boff = 0;
		case (fmt)
			FMT_V210: begin
				start = line + longint'(x / 6) * 4;
				need = 4;
			end
			FMT_2VUY: start = line + longint'(x >> 1);
			FMT_12BE, FMT_12LE: begin
				start = line + (longint'(x) * 6 >> 2);
				boff = int'(x) * 6 % 4;
				need = 2;
			end
			default: start = line + longint'(x);
		endcase
		start = start & ((longint'(1) << POS_W) - 1);
	endfunction

	// one accepted frame word; returns 1 with the report when the word ends a frame
	function automatic bit follow_frame_word(input logic [31:0] word, input logic first,
			input logic last, output pixel_report_t rep);
		logic [12:0]      x;
		logic [12:0]      y;
		longint           start;
		int               need;
		int               boff;
		int               p;
		logic [POS_W-1:0] cur;
		logic [POS_W-1:0] rel;
		logic [127:0]     bytes_le;
		logic [15:0]      h1;
		logic [15:0]      h2;
		logic [15:0]      h3;
		bit               supported;
		bit               found;
		locate_pixel(fmt_cfg, x_cfg, y_cfg, width_cfg, height_cfg, pitch_cfg,
			x, y, start, need, boff);
		supported = fmt_cfg <= FMT_ARGB;
		if (first) begin
			cur = '0;
			captured = 1'b0;
		end else begin
			cur = next_pos;
		end
		next_pos = cur + 1'b1;

		// window capture from the pixel's first word on
		if (supported) begin
			rel = cur - POS_W'(start);
			if (rel < 4) begin
				window[rel[1:0]] = word;
				if (rel == 0)
					captured = 1'b1;
			end
		end
		rep = '0;
		if (!last)
			return 1'b0;

		found = supported && captured && longint'(cur) >= start + need - 1;
		rep.kind = !supported ? KIND_NONE : (fmt_cfg <= FMT_2VUY ? KIND_YCBCR : KIND_RGB);
		rep.column = x;
		rep.row = y;
		rep.found = found;
		if (!found)
			return 1'b1;

		// unpack the components from the captured window
		bytes_le = {window[3], window[2], window[1], window[0]};
		h1 = bytes_le[boff*8 +: 16];
		h2 = bytes_le[boff*8+16 +: 16];
		h3 = bytes_le[boff*8+32 +: 16];
		case (fmt_cfg)
			FMT_V210: begin
				p = x % 6;
				case (p)
					0: rep.comp_one = window[0][19:10];
					1: rep.comp_one = window[1][9:0];
					2: rep.comp_one = window[1][29:20];
					3: rep.comp_one = window[2][19:10];
					4: rep.comp_one = window[3][9:0];
					default: rep.comp_one = window[3][29:20];
				endcase
				if (p < 2) begin
					rep.comp_two = window[0][9:0];
					rep.comp_three = window[0][29:20];
				end else if (p < 4) begin
					rep.comp_two = window[1][19:10];
					rep.comp_three = window[2][9:0];
				end else begin
					rep.comp_two = window[2][29:20];
					rep.comp_three = window[3][19:10];
				end
			end
			FMT_2VUY: begin
				rep.comp_one = x[0] ? window[0][31:24] : window[0][15:8];
				rep.comp_two = window[0][7:0];
				rep.comp_three = window[0][23:16];
			end
			FMT_R210, FMT_R10B: begin
				rep.comp_one = window[0][29:20];
				rep.comp_two = window[0][19:10];
				rep.comp_three = window[0][9:0];
			end
			FMT_R10L: begin
				rep.comp_one = window[0][31:22];
				rep.comp_two = window[0][21:12];
				rep.comp_three = window[0][11:2];
			end
			FMT_12BE: begin
				rep.comp_one = h1[15:4];
				rep.comp_two = h2[15:4];
				rep.comp_three = h3[15:4];
			end
			FMT_12LE: begin
				rep.comp_one = h1[11:0];
				rep.comp_two = h2[11:0];
				rep.comp_three = h3[11:0];
			end
			FMT_BGRA: begin
				rep.comp_one = window[0][23:16];
				rep.comp_two = window[0][15:8];
				rep.comp_three = window[0][7:0];
			end
			FMT_ARGB: begin
				rep.comp_one = window[0][15:8];
				rep.comp_two = window[0][23:16];
				rep.comp_three = window[0][31:24];
			end
			default: ;
		endcase
		return 1'b1;
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic pixel_report_t report(int c1, int c2, int c3, kind_t kind,
			int col, int row, bit found);
		report = '{12'(c1), 12'(c2), 12'(c3), kind, 13'(col), 13'(row), found};
	endfunction

	// receiver: random stall on the report channel
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	// report checking, register mirror and prediction of every accepted word
	always @(posedge clk) begin
		pixel_report_t want;
		pixel_report_t predicted;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_reports.size() == 0) begin
					$display("%0t: report with none awaited: %0d %0d %0d kind %0d found %0d",
						$time, component_one, component_two, component_three,
						colour_kind, pixel_found);
					mismatches++;
				end else begin
					want = awaited_reports.pop_front();
					compare_field("component_one", want.comp_one, component_one);
					compare_field("component_two", want.comp_two, component_two);
					compare_field("component_three", want.comp_three, component_three);
					compare_field("colour_kind", want.kind, colour_kind);
					compare_field("column_used", want.column, column_used);
					compare_field("row_used", want.row, row_used);
					compare_field("pixel_found", want.found, pixel_found);
					reports_checked++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FORMAT:  fmt_cfg = cfg_data[3:0];
					REG_PROBE_X: x_cfg = cfg_data[13:0];
					REG_PROBE_Y: y_cfg = cfg_data[13:0];
					REG_WIDTH:   width_cfg = cfg_data[13:0];
					REG_HEIGHT:  height_cfg = cfg_data[13:0];
					REG_PITCH:   pitch_cfg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				words_sent++;
				if (follow_frame_word(frame_word, first_word, last_word, predicted))
					awaited_reports.push_back(row_known ? row_report : predicted);
			end
		end
	end

	// one word transaction, after a random idle gap
	task automatic send_word(logic [31:0] word, logic first, logic last, bit known = 1'b0,
			pixel_report_t rep = '0);
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_word <= word;
		first_word <= first;
		last_word <= last;
		row_known <= known;
		row_report <= rep;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	// hold input until every awaited report is out and the pipeline has settled
	task automatic drain();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_reg(reg_idx_t idx, logic [15:0] value);
		directed_rows.push_back('{1'b1, idx, value, '0, 1'b0, 1'b0, 1'b0, '0});
	endtask

	task automatic add_word(logic [31:0] word, logic first, logic last, bit known = 1'b0,
			pixel_report_t rep = '0);
		directed_rows.push_back('{1'b0, REG_FORMAT, '0, word, first, last, known, rep});
	endtask

	// stimulus
	initial begin
		logic [3:0]  fmt;
		logic [13:0] px;
		logic [13:0] py;
		logic [13:0] fw;
		logic [13:0] fh;
		logic [15:0] pitch;
		logic [12:0] x;
		logic [12:0] y;
		longint      start;
		int          need;
		int          boff;
		longint      reach;
		int          len;
		int          roll;
		int          budget;
		int          sent;
		bit          lead;
		bit          sloppy;
		bit          have_frame;

		// directed table: reset state, extremes and each packing
		add_word(32'hA5A5_A5A5, 1'b1, 1'b1, 1'b1, report(0, 0, 0, KIND_YCBCR, 960, 540, 0));
		add_reg(REG_FORMAT, 16'd9);
		add_word(32'h0000_0000, 1'b1, 1'b1, 1'b1, report(0, 0, 0, KIND_NONE, 960, 540, 0));
		// most negative column, row of minus one, zero pitch
		add_reg(REG_FORMAT, FMT_BGRA);
		add_reg(REG_PROBE_X, 16'h2000);
		add_reg(REG_PROBE_Y, 16'h3FFF);
		add_reg(REG_PITCH, 16'h0000);
		add_word(32'h1122_3344, 1'b1, 1'b1, 1'b1, report('h22, 'h33, 'h44, KIND_RGB, 0, 0, 1));
		add_reg(REG_FORMAT, FMT_ARGB);
		add_word(32'h1122_3344, 1'b1, 1'b1, 1'b1, report('h33, 'h22, 'h11, KIND_RGB, 0, 0, 1));
		// zero width acts as one, oversize height acts as the maximum
		add_reg(REG_FORMAT, FMT_R210);
		add_reg(REG_PROBE_X, 16'h1FFF);
		add_reg(REG_WIDTH, 16'h0000);
		add_reg(REG_PROBE_Y, 16'h1FFF);
		add_reg(REG_HEIGHT, 16'h3FFF);
		add_word(32'h3FFF_FFFF, 1'b1, 1'b1, 1'b1,
			report('h3FF, 'h3FF, 'h3FF, KIND_RGB, 0, 8191, 1));
		add_reg(REG_FORMAT, FMT_R10L);
		add_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1,
			report('h3FF, 'h3FF, 'h3FF, KIND_RGB, 0, 8191, 1));
		add_reg(REG_FORMAT, FMT_R10B);
		add_word(32'h0000_0000, 1'b1, 1'b1, 1'b1, report(0, 0, 0, KIND_RGB, 0, 8191, 1));
		// unaligned pitch, odd 2vuy pixel
		add_reg(REG_FORMAT, FMT_2VUY);
		add_reg(REG_WIDTH, 16'd1920);
		add_reg(REG_HEIGHT, 16'd2);
		add_reg(REG_PROBE_Y, 16'd1);
		add_reg(REG_PITCH, 16'd7);
		add_reg(REG_PROBE_X, 16'd3);
		add_word($urandom, 1'b1, 1'b0);
		add_word($urandom, 1'b0, 1'b0);
		add_word($urandom, 1'b0, 1'b1);
		// 12-bit pixel straddling a word boundary
		add_reg(REG_PROBE_X, 16'd1);
		add_reg(REG_FORMAT, FMT_12BE);
		add_word($urandom, 1'b1, 1'b0);
		add_word($urandom, 1'b0, 1'b0);
		add_word($urandom, 1'b0, 1'b0);
		add_word($urandom, 1'b0, 1'b1);
		// frame ends too early, then goes on without a first mark
		add_reg(REG_FORMAT, FMT_12LE);
		add_word($urandom, 1'b1, 1'b0);
		add_word($urandom, 1'b0, 1'b0);
		add_word($urandom, 1'b0, 1'b1);
		add_word($urandom, 1'b0, 1'b1);
		// last pixel of a v210 group, then a one-word frame
		add_reg(REG_FORMAT, FMT_V210);
		add_reg(REG_PROBE_X, 16'd5);
		add_reg(REG_PROBE_Y, 16'd0);
		add_reg(REG_PITCH, 16'd0);
		add_word($urandom, 1'b1, 1'b0);
		add_word($urandom, 1'b0, 1'b0);
		add_word($urandom, 1'b0, 1'b0);
		add_word($urandom, 1'b0, 1'b1);
		add_word($urandom, 1'b1, 1'b1);
		add_reg(REG_FORMAT, 16'd15);
		add_word($urandom, 1'b1, 1'b1, 1'b1, report(0, 0, 0, KIND_NONE, 5, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_reg) begin
				if (i == 0 || !directed_rows[i-1].is_reg)
					drain();
				write_reg(directed_rows[i].index, directed_rows[i].value);
			end else begin
				send_word(directed_rows[i].word, directed_rows[i].first, directed_rows[i].last,
					directed_rows[i].known, directed_rows[i].report);
			end
		end

		// random phases, each with its own settings and idling
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 61;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 61;
				end
				default: begin
					send_idle_pct = 31;
					stall_pct = 31;
				end
			endcase

			// settings: mostly small frames so the pixel is reached, sometimes extremes
			fmt = (phase % 10 == 9) ? 4'($urandom_range(9, 15)) : 4'(phase % 10);
			case ($urandom_range(0, 9))
				0: px = 14'($urandom);
				1: px = $urandom_range(0, 1) ? 14'h2000 : 14'h1FFF;
				default: px = 14'($urandom_range(0, 23));
			endcase
			case ($urandom_range(0, 9))
				0: py = 14'($urandom);
				1: py = $urandom_range(0, 1) ? 14'h2000 : 14'h1FFF;
				default: py = 14'($urandom_range(0, 2));
			endcase
			case ($urandom_range(0, 11))
				0: fw = 14'd0;
				1: fw = 14'd8192;
				2: fw = 14'($urandom_range(8193, 16383));
				3: fw = 14'($urandom_range(1, 16383));
				default: fw = 14'($urandom_range(1, 64));
			endcase
			case ($urandom_range(0, 11))
				0: fh = 14'd0;
				1: fh = 14'd8192;
				2: fh = 14'($urandom_range(8193, 16383));
				3: fh = 14'($urandom_range(1, 16383));
				default: fh = 14'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 9))
				0: pitch = 16'($urandom);
				1: pitch = 16'hFFFF;
				default: pitch = 16'($urandom_range(0, 40));
			endcase
			if (phase == RANDOM_PHASES - 1) begin
				fw = 14'd8192;
				fh = 14'd8192;
				px = 14'h1FFF;
				py = 14'h1FFF;
				pitch = 16'hFFFF;
			end

			drain();
			write_reg(REG_FORMAT, 16'(fmt));
			write_reg(REG_PROBE_X, 16'(px));
			write_reg(REG_PROBE_Y, 16'(py));
			write_reg(REG_WIDTH, 16'(fw));
			write_reg(REG_HEIGHT, 16'(fh));
			write_reg(REG_PITCH, pitch);

			locate_pixel(fmt, px, py, fw, fh, pitch, x, y, start, need, boff);
			reach = start + need;
			have_frame = 1'b0;
			budget = RANDOM_WORDS / RANDOM_PHASES;
			sent = 0;
			while (sent < budget) begin
				roll = $urandom_range(0, 99);
				lead = 1'b1;
				sloppy = 1'b0;
				// frame shape: full, cut short, continued without a first mark, or noise
				if (reach > 64)
					len = $urandom_range(1, 12);
				else if (roll < 65)
					len = int'(reach) + $urandom_range(0, 3);
				else if (roll < 80)
					len = (reach > 1) ? $urandom_range(1, int'(reach) - 1) : 1;
				else if (roll < 90 && have_frame) begin
					lead = 1'b0;
					len = $urandom_range(1, 6);
				end else begin
					sloppy = 1'b1;
					len = $urandom_range(1, 6);
				end
				// keep the phase within its word budget
				if (len > budget - sent)
					len = budget - sent;
				for (int k = 0; k < len; k++) begin
					if (sloppy)
						send_word($urandom, (k == 0 && !have_frame) || $urandom_range(0, 3) == 0,
							$urandom_range(0, 3) == 0);
					else
						send_word($urandom, k == 0 && lead, k == len - 1);
				end
				have_frame = 1'b1;
				sent += len;
				// now and then hold the sender until every report is out
				if ($urandom_range(0, 9) == 0)
					drain();
			end
		end

		drain();
		$display("summary: %0d frame words sent, %0d frame-end reports checked",
			words_sent, reports_checked);
		$display("summary: %0d register writes over %0d random phases, %0d mismatches",
			reg_writes, RANDOM_PHASES, mismatches);
		if (mismatches == 0 && awaited_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("timeout: %0d reports still awaited", awaited_reports.size());
		$display("tb: failure");
		$finish;
	end

endmodule
